[design/bmpsd_pkg.sv]
// ----------------------------------------------------------------------------
// BMP stream decoder package
// Shared sizes, codes and structures for the BMP decode and frame store block.
// ----------------------------------------------------------------------------
package bmpsd_pkg;

    // Frame store geometry (power-of-two sizes: the address is {row, column})
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    // Row byte counter holds up to four bytes per pixel across a full row
    localparam int RBC_W       = COL_W + 3;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [31:0] HEADER_END    = 32'd30;
    localparam logic [7:0]  OPAQUE        = 8'd255;

    // Input item modes
    localparam logic [1:0] MODE_FILE_BYTE = 2'd0;
    localparam logic [1:0] MODE_QUERY     = 2'd1;
    localparam logic [1:0] MODE_CLEAR     = 2'd2;

    // Result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Load status codes
    localparam logic [2:0] REJ_OK        = 3'd0;
    localparam logic [2:0] REJ_SIGNATURE = 3'd1;
    localparam logic [2:0] REJ_SIZE      = 3'd2;
    localparam logic [2:0] REJ_DEPTH     = 3'd3;
    localparam logic [2:0] REJ_OFFSET    = 3'd4;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic       kind;
        logic       hit;
        logic       loaded;
        logic [2:0] reject_code;
    } result_meta_t;

endpackage

[design/bmpsd_parser.sv]
// ----------------------------------------------------------------------------
// BMP stream parser
// Header capture, checks, row and pixel tracking, frame store write and read
// requests for each accepted item.
// ----------------------------------------------------------------------------
module bmpsd_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [1:0]             mode,
    input  logic [7:0]             byte_value,
    input  logic                   last_byte,
    input  logic [15:0]            pixel_x,
    input  logic [15:0]            pixel_y,
    output bmpsd_pkg::store_wr_t    wr,
    output bmpsd_pkg::store_rd_t    rd,
    output logic                   res_valid,
    output bmpsd_pkg::result_meta_t res
);

    localparam int COL_W = bmpsd_pkg::COL_W;
    localparam int ROW_W = bmpsd_pkg::ROW_W;
    localparam int RBC_W = bmpsd_pkg::RBC_W;

    logic [31:0]      pos_reg,    pos_next;
    logic [15:0]      sig_reg,    sig_next;
    logic [31:0]      offset_reg, offset_next;
    logic [31:0]      width_reg,  width_next;
    logic [31:0]      height_reg, height_next;
    logic [15:0]      bpp_reg,    bpp_next;
    logic [ROW_W:0]   row_reg,    row_next;
    logic [RBC_W-1:0] rbc_reg,    rbc_next;
    logic [1:0]       chan_reg,   chan_next;
    logic [COL_W:0]   col_reg,    col_next;
    logic [23:0]      asm_reg,    asm_next;
    logic             loaded_reg, loaded_next;

    logic             start;
    logic [1:0]       lane;
    logic [2:0]       code_next;
    logic             chl4;
    logic [RBC_W-1:0] row_bytes;
    logic [RBC_W-1:0] row_bytes_p3;
    logic [RBC_W-1:0] padded;
    logic [RBC_W-1:0] rbc_inc;
    logic             last_chan;
    logic [23:0]      asm_new;
    logic             hit;

    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] ln,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[{ln, 3'b000} +: 8] = r[{ln, 3'b000} +: 8] | b;
        return r;
    endfunction

    function automatic logic [2:0] hdr_check(input logic [15:0] s, input logic [31:0] o,
                                             input logic [31:0] w, input logic [31:0] h,
                                             input logic [15:0] d);
        logic [2:0] c;
        if (s != bmpsd_pkg::BMP_SIGNATURE)
            c = bmpsd_pkg::REJ_SIGNATURE;
        else if (w == 32'd0 || w > 32'(bmpsd_pkg::MAX_WIDTH) ||
                 h == 32'd0 || h > 32'(bmpsd_pkg::MAX_HEIGHT))
            c = bmpsd_pkg::REJ_SIZE;
        else if (d != 16'd24 && d != 16'd32)
            c = bmpsd_pkg::REJ_DEPTH;
        else if (o < bmpsd_pkg::HEADER_END)
            c = bmpsd_pkg::REJ_OFFSET;
        else
            c = bmpsd_pkg::REJ_OK;
        return c;
    endfunction

    assign start = (pos_reg == 32'd0);
    // Offset, width and height fields all begin at a position that is 2 mod 4
    assign lane  = pos_reg[1:0] - 2'd2;

    // Depth is 24 or 32 whenever pixel bytes are taken
    assign chl4         = bpp_reg[5];
    assign row_bytes    = chl4 ? {width_reg[COL_W:0], 2'b00}
                               : ({1'b0, width_reg[COL_W:0], 1'b0}
                                  + {2'b00, width_reg[COL_W:0]});
    assign row_bytes_p3 = row_bytes + RBC_W'(3);
    assign padded       = {row_bytes_p3[RBC_W-1:2], 2'b00};
    assign rbc_inc      = rbc_reg + RBC_W'(1);
    assign last_chan    = chl4 ? (chan_reg == 2'd3) : (chan_reg == 2'd2);

    always_comb
    begin
        case (chan_reg)
            2'd0:    asm_new = {16'd0, byte_value};
            2'd1:    asm_new = asm_reg | {8'd0, byte_value, 8'd0};
            2'd2:    asm_new = asm_reg | {byte_value, 16'd0};
            default: asm_new = asm_reg;
        endcase
    end

    assign hit = loaded_reg && ({16'd0, pixel_x} < width_reg)
                            && ({16'd0, pixel_y} < height_reg);

    always_comb
    begin
        pos_next    = pos_reg;
        sig_next    = sig_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        height_next = height_reg;
        bpp_next    = bpp_reg;
        row_next    = row_reg;
        rbc_next    = rbc_reg;
        chan_next   = chan_reg;
        col_next    = col_reg;
        asm_next    = asm_reg;
        loaded_next = loaded_reg;
        code_next   = bmpsd_pkg::REJ_OK;
        wr          = '0;
        rd          = '0;
        res_valid   = 1'b0;
        res         = '0;

        if (accept)
        begin
            unique case (mode)
                bmpsd_pkg::MODE_FILE_BYTE:
                begin
                    if (start)
                    begin
                        loaded_next = 1'b0;
                        sig_next    = '0;
                        offset_next = '0;
                        width_next  = '0;
                        height_next = '0;
                        bpp_next    = '0;
                        row_next    = '0;
                        rbc_next    = '0;
                        chan_next   = '0;
                        col_next    = '0;
                        asm_next    = '0;
                    end

                    if (pos_reg < 32'd2)
                    begin
                        if (pos_reg[0])
                            sig_next[15:8] = sig_next[15:8] | byte_value;
                        else
                            sig_next[7:0] = sig_next[7:0] | byte_value;
                    end
                    else if (pos_reg >= 32'd10 && pos_reg < 32'd14)
                        offset_next = put_byte(offset_reg, lane, byte_value);
                    else if (pos_reg >= 32'd18 && pos_reg < 32'd22)
                        width_next = put_byte(width_reg, lane, byte_value);
                    else if (pos_reg >= 32'd22 && pos_reg < 32'd26)
                        height_next = put_byte(height_reg, lane, byte_value);
                    else if (pos_reg >= 32'd28 && pos_reg < 32'd30)
                    begin
                        if (pos_reg[0])
                            bpp_next[15:8] = bpp_reg[15:8] | byte_value;
                        else
                            bpp_next[7:0] = bpp_reg[7:0] | byte_value;
                    end

                    code_next = hdr_check(sig_next, offset_next, width_next,
                                          height_next, bpp_next);

                    // Past the header the fields are final, so the check applies as is
                    if (pos_reg >= bmpsd_pkg::HEADER_END && pos_reg >= offset_reg &&
                        code_next == bmpsd_pkg::REJ_OK &&
                        row_reg < height_reg[ROW_W:0])
                    begin
                        if (rbc_reg < row_bytes)
                        begin
                            asm_next = asm_new;
                            if (last_chan)
                            begin
                                wr.en     = 1'b1;
                                wr.addr   = {row_reg[ROW_W-1:0], col_reg[COL_W-1:0]};
                                wr.data   = chl4 ? {byte_value, asm_reg}
                                                 : {bmpsd_pkg::OPAQUE, asm_new};
                                chan_next = 2'd0;
                                col_next  = col_reg + (COL_W+1)'(1);
                            end
                            else
                                chan_next = chan_reg + 2'd1;
                        end
                        // Drop padding; advance to the next row at the padded length
                        if (rbc_inc >= padded)
                        begin
                            rbc_next  = '0;
                            row_next  = row_reg + (ROW_W+1)'(1);
                            chan_next = 2'd0;
                            col_next  = '0;
                        end
                        else
                            rbc_next = rbc_inc;
                    end

                    if (pos_reg != 32'hFFFF_FFFF)
                        pos_next = pos_reg + 32'd1;

                    if (last_byte)
                    begin
                        loaded_next     = (code_next == bmpsd_pkg::REJ_OK);
                        pos_next        = '0;
                        res_valid       = 1'b1;
                        res.kind        = bmpsd_pkg::KIND_STATUS;
                        res.hit         = 1'b0;
                        res.loaded      = (code_next == bmpsd_pkg::REJ_OK);
                        res.reject_code = code_next;
                    end
                end

                bmpsd_pkg::MODE_QUERY:
                begin
                    // Flip the bottom-up file rows
                    rd.en           = 1'b1;
                    rd.addr         = {height_reg[ROW_W-1:0] - ROW_W'(1)
                                       - pixel_y[ROW_W-1:0], pixel_x[COL_W-1:0]};
                    res_valid       = 1'b1;
                    res.kind        = bmpsd_pkg::KIND_PIXEL;
                    res.hit         = hit;
                    res.loaded      = loaded_reg;
                    res.reject_code = bmpsd_pkg::REJ_OK;
                end

                bmpsd_pkg::MODE_CLEAR:
                begin
                    loaded_next = 1'b0;
                    width_next  = '0;
                    height_next = '0;
                    bpp_next    = '0;
                    pos_next    = '0;
                end

                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sig_reg    <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            bpp_reg    <= '0;
            row_reg    <= '0;
            rbc_reg    <= '0;
            chan_reg   <= '0;
            col_reg    <= '0;
            asm_reg    <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sig_reg    <= sig_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            bpp_reg    <= bpp_next;
            row_reg    <= row_next;
            rbc_reg    <= rbc_next;
            chan_reg   <= chan_next;
            col_reg    <= col_next;
            asm_reg    <= asm_next;
            loaded_reg <= loaded_next;
        end
    end

endmodule

[design/bmp_stream_decode_store_unit.sv]
// ----------------------------------------------------------------------------
// BMP stream decode and store unit
// Loads a 24/32-bit BMP file byte by byte into a frame store and answers
// pixel queries against it.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per handshake: tuser selects a file
//   byte, a pixel query or a clear; tlast marks the final file byte. The
//   master stream returns a status item after each final byte (tuser high)
//   and a pixel item for each query (tuser low); other items give nothing.
//   Pixel bytes are written into a 32-bit frame store with a registered read;
//   the write is done on the cycle the byte is taken, so a query that
//   follows at once already sees it. A result reaches the master side
//   through the store read register, then the output register.
//   Throughput is one item per cycle while the receiver keeps up; the frame
//   store has a single write port and a single read port.
//   Reset clears the header state and the loaded mark; the store contents
//   stay undefined until written, and no clearing pass is run.
//   When the receiver stalls, the output register and the read stage hold;
//   s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module bmp_stream_decode_store_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // byte_value[7:0], pixel_x[23:8], pixel_y[39:24]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // hit[0], red[8:1], green[16:9], blue[24:17],
                                        // alpha[32:25], loaded[33], reject_code[36:34]
    output logic        m_axis_tuser    // kind
);

    logic                    accept;
    bmpsd_pkg::store_wr_t    wr;
    bmpsd_pkg::store_rd_t    rd;
    logic                    res_valid;
    bmpsd_pkg::result_meta_t res;

    logic [31:0] store_mem [bmpsd_pkg::STORE_DEPTH];
    logic [31:0] q_reg;

    logic                    s1_valid_reg;
    bmpsd_pkg::result_meta_t s1_meta_reg;
    logic                    s1_move;
    logic                    out_valid_reg;
    logic [39:0]             out_data_reg, out_data_next;
    logic                    out_kind_reg;

    assign s_axis_tready = !s1_valid_reg || !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);

    bmpsd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (s_axis_tuser),
        .byte_value (s_axis_tdata[7:0]),
        .last_byte  (s_axis_tlast),
        .pixel_x    (s_axis_tdata[23:8]),
        .pixel_y    (s_axis_tdata[39:24]),
        .wr         (wr),
        .rd         (rd),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge clk)
    begin
        if (wr.en)
            store_mem[wr.addr] <= wr.data;
        if (rd.en)
            q_reg <= store_mem[rd.addr];
    end

    // Zero the channels when there is no hit
    always_comb
    begin
        out_data_next = '0;
        out_data_next[0] = s1_meta_reg.hit;
        if (s1_meta_reg.hit)
        begin
            out_data_next[8:1]   = q_reg[23:16];
            out_data_next[16:9]  = q_reg[15:8];
            out_data_next[24:17] = q_reg[7:0];
            out_data_next[32:25] = q_reg[31:24];
        end
        out_data_next[33]    = s1_meta_reg.loaded;
        out_data_next[36:34] = s1_meta_reg.reject_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= res_valid;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_meta_reg <= res;
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= s1_meta_reg.kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// BMP stream decode and store unit testbench
// Streams BMP files, clears and pixel queries into the block with random
// gaps and receiver stalls, predicts every status and pixel answer with a
// behavioral copy of the decoder and frame store, and checks each answer
// field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int          RESET_CYCLES = 5;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned TOTAL_ITEMS  = 1400;

    typedef struct {
        bit [1:0]    mode;
        bit [7:0]    byte_value;
        bit          last_byte;
        bit [15:0]   pixel_x;
        bit [15:0]   pixel_y;
        int unsigned gap;
    } bmp_item_t;

    typedef struct {
        bit       kind;
        bit       hit;
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [7:0] alpha;
        bit       loaded;
        bit [2:0] reject_code;
    } bmp_answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // byte_value[7:0], pixel_x[23:8], pixel_y[39:24]
    logic [1:0]  s_axis_tuser = '0;     // mode[1:0]
    logic        s_axis_tlast = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // hit[0], red[8:1], green[16:9], blue[24:17],
                                        // alpha[32:25], loaded[33], reject_code[36:34]
    logic        m_axis_tuser;          // kind

    bmp_item_t   stream_items[$];
    bmp_answer_t answer_queue[$];
    bit [7:0]    file_bytes[$];

    int unsigned mismatch_count;
    int unsigned issued_items;
    int unsigned tx_burst;
    int unsigned rx_burst;
    int unsigned rx_wait;
    int unsigned send_wait;
    int unsigned cycle_count;
    logic        s_taken = 1'b0;

    // Decoder state mirror
    bit [31:0] pos_cnt;
    bit [15:0] hdr_sig;
    bit [31:0] hdr_offset;
    bit [31:0] img_w;
    bit [31:0] img_h;
    bit [15:0] img_bpp;
    bit [15:0] row_idx;
    bit [15:0] row_byte_idx;
    bit [23:0] pix_acc;
    bit        img_loaded;
    bit [31:0] frame_mirror [bmpsd_pkg::STORE_DEPTH];
    bit        frame_written [bmpsd_pkg::STORE_DEPTH];

    bmp_stream_decode_store_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic int unsigned draw_wait(inout int unsigned burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        // open a stretch with no idling now and then
        if ($urandom_range(0, 39) == 0)
        begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic bit [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bit [31:0] bad_size();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'(bmpsd_pkg::MAX_WIDTH + 1 + $urandom_range(0, 100));
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [2:0] header_status();
        if (hdr_sig != bmpsd_pkg::BMP_SIGNATURE) return bmpsd_pkg::REJ_SIGNATURE;
        if (img_w == 0 || img_w > bmpsd_pkg::MAX_WIDTH) return bmpsd_pkg::REJ_SIZE;
        if (img_h == 0 || img_h > bmpsd_pkg::MAX_HEIGHT) return bmpsd_pkg::REJ_SIZE;
        if (img_bpp != 24 && img_bpp != 32) return bmpsd_pkg::REJ_DEPTH;
        if (hdr_offset < bmpsd_pkg::HEADER_END) return bmpsd_pkg::REJ_OFFSET;
        return bmpsd_pkg::REJ_OK;
    endfunction

    function automatic void open_file();
        img_loaded   = 1'b0;
        hdr_sig      = '0;
        hdr_offset   = '0;
        img_w        = '0;
        img_h        = '0;
        img_bpp      = '0;
        row_idx      = '0;
        row_byte_idx = '0;
        pix_acc      = '0;
    endfunction

    function automatic void store_pixel_byte(input bit [7:0] b);
        int unsigned chl, row_bytes, padded, k, addr;
        bit [7:0]    a;
        chl       = img_bpp >> 3;
        row_bytes = img_w * chl;
        padded    = (row_bytes + 3) & ~32'd3;
        if (chl == 0 || row_idx >= img_h) return;
        if (row_byte_idx < row_bytes)
        begin
            k = row_byte_idx % chl;
            a = bmpsd_pkg::OPAQUE;
            if (k == 0) pix_acc = {16'd0, b};
            else if (k < 3) pix_acc = pix_acc | (24'(b) << (8 * k));
            else a = b;
            if (k == chl - 1)
            begin
                addr = row_idx * bmpsd_pkg::MAX_WIDTH + row_byte_idx / chl;
                if (addr < bmpsd_pkg::STORE_DEPTH)
                begin
                    frame_mirror[addr]  = {a, pix_acc};
                    frame_written[addr] = 1'b1;
                end
            end
        end
        row_byte_idx++;
        // drop the row padding, advance to the next file row
        if (row_byte_idx >= padded)
        begin
            row_byte_idx = '0;
            row_idx++;
        end
    endfunction

    function automatic bit query_hits(input bit [15:0] px, input bit [15:0] py);
        return img_loaded && px < img_w && py < img_h;
    endfunction

    function automatic int unsigned query_addr(input bit [15:0] px, input bit [15:0] py);
        return (img_h - 1 - py) * bmpsd_pkg::MAX_WIDTH + px;
    endfunction

    // Advance the decoder mirror by one item and queue the answer it causes
    function automatic void decode_and_answer(input bmp_item_t it);
        bit [31:0]   p, bw, word;
        bit [2:0]    code;
        bmp_answer_t ans;
        bw  = {24'd0, it.byte_value};
        ans = '{default: 0};
        case (it.mode)
            bmpsd_pkg::MODE_FILE_BYTE:
            begin
                p = pos_cnt;
                if (p == 0) open_file();
                if (p < 2) hdr_sig = hdr_sig | 16'(bw << (8 * p));
                else if (p >= 10 && p < 14) hdr_offset = hdr_offset | (bw << (8 * (p - 10)));
                else if (p >= 18 && p < 22) img_w = img_w | (bw << (8 * (p - 18)));
                else if (p >= 22 && p < 26) img_h = img_h | (bw << (8 * (p - 22)));
                else if (p >= 28 && p < 30) img_bpp = img_bpp | 16'(bw << (8 * (p - 28)));
                else if (p >= bmpsd_pkg::HEADER_END && p >= hdr_offset &&
                         header_status() == bmpsd_pkg::REJ_OK)
                    store_pixel_byte(it.byte_value);
                if (pos_cnt != '1) pos_cnt++;
                if (it.last_byte)
                begin
                    code            = header_status();
                    img_loaded      = (code == bmpsd_pkg::REJ_OK);
                    pos_cnt         = '0;
                    ans.kind        = bmpsd_pkg::KIND_STATUS;
                    ans.loaded      = img_loaded;
                    ans.reject_code = code;
                    answer_queue.push_back(ans);
                end
            end
            bmpsd_pkg::MODE_QUERY:
            begin
                word = '0;
                ans.hit = query_hits(it.pixel_x, it.pixel_y);
                if (ans.hit) word = frame_mirror[query_addr(it.pixel_x, it.pixel_y)];
                ans.kind        = bmpsd_pkg::KIND_PIXEL;
                ans.red         = word[23:16];
                ans.green       = word[15:8];
                ans.blue        = word[7:0];
                ans.alpha       = word[31:24];
                ans.loaded      = img_loaded;
                ans.reject_code = bmpsd_pkg::REJ_OK;
                answer_queue.push_back(ans);
            end
            bmpsd_pkg::MODE_CLEAR:
            begin
                img_loaded = 1'b0;
                img_w      = '0;
                img_h      = '0;
                img_bpp    = '0;
                pos_cnt    = '0;
            end
            default: ;
        endcase
    endfunction

    task automatic push_item(input bit [1:0] mode, input bit [7:0] b, input bit last,
                             input bit [15:0] px, input bit [15:0] py);
        bmp_item_t it;
        it.mode       = mode;
        it.byte_value = b;
        it.last_byte  = last;
        it.pixel_x    = px;
        it.pixel_y    = py;
        it.gap        = draw_wait(tx_burst);
        stream_items.push_back(it);
        decode_and_answer(it);
        if (mode != MODE_UNUSED) issued_items++;
    endtask

    task automatic push_query(input bit [15:0] px, input bit [15:0] py);
        // steer away from store entries that no file has written yet
        if (query_hits(px, py) && !frame_written[query_addr(px, py)])
            px = 16'(img_w + $urandom_range(0, 65535 - img_w));
        push_item(bmpsd_pkg::MODE_QUERY, rand_byte(), 1'($urandom), px, py);
    endtask

    task automatic query_burst(input int n);
        bit [15:0] qx, qy;
        bit        fits;
        repeat (n)
        begin
            fits = img_w >= 1 && img_w <= bmpsd_pkg::MAX_WIDTH &&
                   img_h >= 1 && img_h <= bmpsd_pkg::MAX_HEIGHT;
            qx = 16'($urandom);
            qy = 16'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    if (fits)
                    begin
                        qx = 16'($urandom_range(0, img_w - 1));
                        qy = 16'($urandom_range(0, img_h - 1));
                    end
                6:
                    if (fits)
                    begin
                        qx = $urandom_range(0, 1) ? 16'(img_w) : 16'($urandom_range(0, img_w - 1));
                        qy = (qx == img_w) ? 16'($urandom_range(0, img_h - 1)) : 16'(img_h);
                    end
                7:
                begin
                    qx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    qy = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                8: push_item(MODE_UNUSED, rand_byte(), 1'($urandom), qx, qy);
                default: ;
            endcase
            push_query(qx, qy);
        end
    endtask

    task automatic build_file(input bit [15:0] sig, input bit [31:0] off, input bit [31:0] w,
                              input bit [31:0] h, input bit [15:0] bpp);
        int unsigned chl, n_data;
        file_bytes.delete();
        for (int i = 0; i < 30; i++) file_bytes.push_back(rand_byte());
        file_bytes[0] = sig[7:0];
        file_bytes[1] = sig[15:8];
        for (int i = 0; i < 4; i++)
        begin
            file_bytes[10 + i] = off[8 * i +: 8];
            file_bytes[18 + i] = w[8 * i +: 8];
            file_bytes[22 + i] = h[8 * i +: 8];
        end
        file_bytes[28] = bpp[7:0];
        file_bytes[29] = bpp[15:8];
        // filler between the header and the pixel data
        if (off > bmpsd_pkg::HEADER_END && off <= 200)
            repeat (off - bmpsd_pkg::HEADER_END) file_bytes.push_back(rand_byte());
        chl = bpp >> 3;
        if (w <= bmpsd_pkg::MAX_WIDTH && h <= bmpsd_pkg::MAX_HEIGHT && (bpp == 24 || bpp == 32))
            n_data = h * ((w * chl + 3) & ~32'd3);
        else
            n_data = $urandom_range(0, 24);
        repeat (n_data) file_bytes.push_back(rand_byte());
        repeat ($urandom_range(0, 3)) file_bytes.push_back(rand_byte());
    endtask

    task automatic send_file(input int unsigned len, input bit noisy, input bit with_last);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 24) == 0)
            begin
                if ($urandom_range(0, 1)) push_query(16'($urandom), 16'($urandom));
                else push_item(MODE_UNUSED, rand_byte(), 1'($urandom), 16'($urandom), 16'($urandom));
            end
            push_item(bmpsd_pkg::MODE_FILE_BYTE, file_bytes[i], with_last && i == len - 1,
                      16'($urandom), 16'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (stream_items.size() != 0 || s_axis_tvalid || answer_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Item driver: hold an item until taken, then idle for its drawn gap
    always @(posedge clk) s_taken <= s_axis_tvalid && s_axis_tready;

    always @(negedge clk)
    begin : item_driver
        bmp_item_t cur;
        if (rst_n && (!s_axis_tvalid || s_taken))
        begin
            if (send_wait > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_wait--;
            end
            else if (stream_items.size() > 0)
            begin
                cur = stream_items.pop_front();
                s_axis_tdata  <= {cur.pixel_y, cur.pixel_x, cur.byte_value};
                s_axis_tuser  <= cur.mode;
                s_axis_tlast  <= cur.last_byte;
                s_axis_tvalid <= 1'b1;
                send_wait = cur.gap;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_wait > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        bmp_answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (answer_queue.size() == 0)
            begin
                $error("result item with no expected answer pending");
                mismatch_count++;
            end
            else
            begin
                want = answer_queue.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("hit", want.hit, m_axis_tdata[0]);
                check_field("red", want.red, m_axis_tdata[8:1]);
                check_field("green", want.green, m_axis_tdata[16:9]);
                check_field("blue", want.blue, m_axis_tdata[24:17]);
                check_field("alpha", want.alpha, m_axis_tdata[32:25]);
                check_field("loaded", want.loaded, m_axis_tdata[33]);
                check_field("reject_code", want.reject_code, m_axis_tdata[36:34]);
            end
            rx_wait = draw_wait(rx_burst);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** bmp_stream_decode_store_unit: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        bit [15:0]   sig, bpp;
        bit [31:0]   off, w, h;
        int unsigned sel;
        bit          noisy;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty queries, ignored mode, clear, one-byte file, tiny images
        push_query(16'h0000, 16'h0000);
        push_query(16'hFFFF, 16'hFFFF);
        push_item(MODE_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
        push_item(bmpsd_pkg::MODE_CLEAR, 8'h00, 1'b0, 16'h0000, 16'h0000);
        push_item(bmpsd_pkg::MODE_FILE_BYTE, 8'hFF, 1'b1, 16'hFFFF, 16'h0000);
        build_file(bmpsd_pkg::BMP_SIGNATURE, bmpsd_pkg::HEADER_END, 32'd1, 32'd1, 16'd24);
        send_file(file_bytes.size(), 1'b0, 1'b1);
        push_query(16'd0, 16'd0);
        push_query(16'd1, 16'd0);
        push_query(16'd0, 16'd1);
        build_file(bmpsd_pkg::BMP_SIGNATURE, 32'd31, 32'd2, 32'd2, 16'd32);
        send_file(file_bytes.size(), 1'b0, 1'b1);
        push_query(16'd0, 16'd0);
        push_query(16'd1, 16'd1);
        push_query(16'd2, 16'd1);
        push_item(bmpsd_pkg::MODE_CLEAR, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
        push_query(16'd0, 16'd0);

        // Hold the sender until every answer so far is back
        wait_drained();

        // Full-width image, then a full-height image cut short after a few rows
        build_file(bmpsd_pkg::BMP_SIGNATURE, 32'd54, 32'(bmpsd_pkg::MAX_WIDTH), 32'd1, 16'd24);
        send_file(file_bytes.size(), 1'b0, 1'b1);
        push_query(16'd0, 16'd0);
        push_query(16'(bmpsd_pkg::MAX_WIDTH - 1), 16'd0);
        push_query(16'(bmpsd_pkg::MAX_WIDTH), 16'd0);
        push_query(16'd0, 16'd1);
        query_burst(12);
        build_file(bmpsd_pkg::BMP_SIGNATURE, bmpsd_pkg::HEADER_END, 32'd1,
                   32'(bmpsd_pkg::MAX_HEIGHT), 16'd32);
        send_file(bmpsd_pkg::HEADER_END + 32'd96, 1'b1, 1'b1);
        push_query(16'd0, 16'd0);
        push_query(16'd0, 16'(bmpsd_pkg::MAX_HEIGHT - 1));
        push_query(16'd0, 16'(bmpsd_pkg::MAX_HEIGHT));
        push_query(16'd1, 16'(bmpsd_pkg::MAX_HEIGHT - 1));
        query_burst(12);

        while (issued_items < TOTAL_ITEMS)
        begin
            w     = $urandom_range(1, 8);
            h     = $urandom_range(1, 6);
            bpp   = $urandom_range(0, 1) ? 16'd24 : 16'd32;
            off   = ($urandom_range(0, 3) == 0) ? bmpsd_pkg::HEADER_END
                                                : 32'($urandom_range(31, 70));
            sig   = bmpsd_pkg::BMP_SIGNATURE;
            noisy = ($urandom_range(0, 3) == 0);
            // pixel data that starts past the end of the file
            if ($urandom_range(0, 19) == 0) off = 32'h8000_0000 | 32'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 60)
            begin
                build_file(sig, off, w, h, bpp);
                send_file(file_bytes.size(), noisy, 1'b1);
                query_burst($urandom_range(3, 10));
            end
            else if (sel < 72)
            begin
                build_file(sig, off, w, h, bpp);
                send_file($urandom_range(1, file_bytes.size()), noisy, 1'b1);
                query_burst($urandom_range(3, 6));
            end
            else if (sel < 87)
            begin
                case ($urandom_range(0, 4))
                    0: sig = sig ^ 16'($urandom_range(1, 65535));
                    1: w = bad_size();
                    2: h = bad_size();
                    3:
                        case ($urandom_range(0, 4))
                            0: bpp = 16'd0;
                            1: bpp = 16'd16;
                            2: bpp = 16'd8;
                            3: bpp = 16'd24 | (16'd1 << $urandom_range(8, 15));
                            default: bpp = 16'($urandom);
                        endcase
                    default: off = $urandom_range(0, 29);
                endcase
                build_file(sig, off, w, h, bpp);
                send_file(file_bytes.size(), noisy, 1'b1);
                query_burst($urandom_range(1, 3));
            end
            else if (sel < 93)
            begin
                // abort a file part way, then load a fresh one
                build_file(sig, off, w, h, bpp);
                send_file($urandom_range(1, file_bytes.size() - 1), 1'b0, 1'b0);
                push_item(bmpsd_pkg::MODE_CLEAR, rand_byte(), 1'($urandom),
                          16'($urandom), 16'($urandom));
                push_query(16'($urandom_range(0, 7)), 16'($urandom_range(0, 5)));
                build_file(sig, bmpsd_pkg::HEADER_END, w, h, bpp);
                send_file(file_bytes.size(), noisy, 1'b1);
                query_burst($urandom_range(2, 6));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        push_item(bmpsd_pkg::MODE_CLEAR, rand_byte(), 1'($urandom),
                                  16'($urandom), 16'($urandom));
                        query_burst(2);
                    end
                    1: push_item(MODE_UNUSED, rand_byte(), 1'($urandom),
                                 16'($urandom), 16'($urandom));
                    2: push_item(bmpsd_pkg::MODE_FILE_BYTE, rand_byte(), 1'b1,
                                 16'($urandom), 16'($urandom));
                    default: query_burst(3);
                endcase
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && answer_queue.size() == 0)
            $display("** bmp_stream_decode_store_unit: PASSED **");
        else
            $display("** bmp_stream_decode_store_unit: FAILED **");
        $finish;
    end

endmodule
